>>> src/cab_pkg.sv
// ----------------------------------------------------------------------------
// cab_pkg
// Shared types and constants for the clipped alpha blit.
// ----------------------------------------------------------------------------
package cab_pkg;

	localparam int MAX_DIM_DEFAULT = 4096;
	// Largest value a 13-bit size register can hold
	localparam int SIZE_REG_MAX    = 8191;

	localparam int CENTER_W = 14;
	localparam int SIZE_W   = 13;
	localparam int CFG_W    = 14;
	localparam int IDX_W    = 3;
	localparam int PIX_W    = 32;
	localparam int RGB_W    = 24;
	localparam int COORD_W  = 12;
	// Signed frame position: center (14b) minus half size plus count (13b max)
	localparam int POS_W    = 16;

	typedef enum logic [IDX_W-1:0] {
		CFG_CENTER_X      = 3'd0,
		CFG_CENTER_Y      = 3'd1,
		CFG_BITMAP_WIDTH  = 3'd2,
		CFG_BITMAP_HEIGHT = 3'd3,
		CFG_FRAME_WIDTH   = 3'd4,
		CFG_FRAME_HEIGHT  = 3'd5
	} cfg_idx_t;

	// Register file contents; sizes are stored already clamped
	typedef struct packed {
		logic signed [CENTER_W-1:0] center_x;
		logic signed [CENTER_W-1:0] center_y;
		logic        [SIZE_W-1:0]   bitmap_width;
		logic        [SIZE_W-1:0]   bitmap_height;
		logic        [SIZE_W-1:0]   frame_width;
		logic        [SIZE_W-1:0]   frame_height;
	} cab_cfg_t;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic                    last;
	} cab_pos_t;

	typedef struct packed {
		logic [PIX_W-1:0] source_pixel;
		logic [PIX_W-1:0] dest_pixel;
	} cab_in_t;

	typedef struct packed {
		logic               write_enable;
		logic [COORD_W-1:0] dest_x;
		logic [COORD_W-1:0] dest_y;
		logic [RGB_W-1:0]   blended_pixel;
		logic               last;
	} cab_out_t;

endpackage

>>> src/cab_cfg_regs.sv
// ----------------------------------------------------------------------------
// cab_cfg_regs
// Configuration register file; sizes are clamped to 1..MAX_DIM on write.
// ----------------------------------------------------------------------------
module cab_cfg_regs #(
	parameter int MAX_DIM = cab_pkg::MAX_DIM_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [cab_pkg::IDX_W-1:0]    wr_index,
	input  logic [cab_pkg::CFG_W-1:0]    wr_data,
	output cab_pkg::cab_cfg_t            cfg
);

	localparam int CMP_W = cab_pkg::SIZE_W + 3;

	cab_pkg::cab_cfg_t cfg_q;
	logic [cab_pkg::SIZE_W-1:0] raw_size;
	logic [cab_pkg::SIZE_W-1:0] eff_size;

	assign raw_size = wr_data[cab_pkg::SIZE_W-1:0];

	always_comb begin
		if (raw_size == '0) begin
			eff_size = cab_pkg::SIZE_W'(1);
		end else if (CMP_W'(raw_size) > CMP_W'(MAX_DIM)) begin
			eff_size = cab_pkg::SIZE_W'(MAX_DIM);
		end else begin
			eff_size = raw_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x      <= '0;
			cfg_q.center_y      <= '0;
			cfg_q.bitmap_width  <= cab_pkg::SIZE_W'(1);
			cfg_q.bitmap_height <= cab_pkg::SIZE_W'(1);
			cfg_q.frame_width   <= cab_pkg::SIZE_W'(1);
			cfg_q.frame_height  <= cab_pkg::SIZE_W'(1);
		end else if (wr_en) begin
			unique case (wr_index)
				cab_pkg::CFG_CENTER_X:      cfg_q.center_x      <= $signed(wr_data);
				cab_pkg::CFG_CENTER_Y:      cfg_q.center_y      <= $signed(wr_data);
				cab_pkg::CFG_BITMAP_WIDTH:  cfg_q.bitmap_width  <= eff_size;
				cab_pkg::CFG_BITMAP_HEIGHT: cfg_q.bitmap_height <= eff_size;
				cab_pkg::CFG_FRAME_WIDTH:   cfg_q.frame_width   <= eff_size;
				cab_pkg::CFG_FRAME_HEIGHT:  cfg_q.frame_height  <= eff_size;
				default: ; // unmapped index, ignored
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/cab_addr_gen.sv
// ----------------------------------------------------------------------------
// cab_addr_gen
// Raster column/row counters and frame position of the current item.
// ----------------------------------------------------------------------------
module cab_addr_gen #(
	parameter int MAX_DIM = cab_pkg::MAX_DIM_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  cab_pkg::cab_cfg_t cfg,
	output cab_pkg::cab_pos_t pos
);

	localparam int EFF_MAX = (MAX_DIM < cab_pkg::SIZE_REG_MAX) ? MAX_DIM
	                                                            : cab_pkg::SIZE_REG_MAX;
	localparam int CNT_W   = $clog2(EFF_MAX);
	localparam int CMP_W   = cab_pkg::SIZE_W + 1;
	localparam int POS_W   = cab_pkg::POS_W;

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic             end_col;
	logic             end_row;

	logic signed [POS_W-1:0] cx_ext;
	logic signed [POS_W-1:0] cy_ext;
	logic        [POS_W-1:0] half_w;
	logic        [POS_W-1:0] half_h;
	logic        [POS_W-1:0] col_ext;
	logic        [POS_W-1:0] row_ext;

	// A count at or past the last column (e.g. after a size change) wraps
	assign end_col = (CMP_W'(col_q) + CMP_W'(1)) >= CMP_W'(cfg.bitmap_width);
	assign end_row = (CMP_W'(row_q) + CMP_W'(1)) >= CMP_W'(cfg.bitmap_height);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (end_col) begin
				col_q <= '0;
				row_q <= end_row ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		cx_ext  = POS_W'(cfg.center_x);
		cy_ext  = POS_W'(cfg.center_y);
		half_w  = POS_W'(cfg.bitmap_width >> 1);
		half_h  = POS_W'(cfg.bitmap_height >> 1);
		col_ext = POS_W'(col_q);
		row_ext = POS_W'(row_q);
		pos.x    = cx_ext - $signed(half_w) + $signed(col_ext);
		pos.y    = cy_ext - $signed(half_h) + $signed(row_ext);
		pos.last = end_col && end_row;
	end

endmodule

>>> src/cab_blend.sv
// ----------------------------------------------------------------------------
// cab_blend
// Frame clipping and per-channel alpha blend, floor(t/255) in fixed point.
// ----------------------------------------------------------------------------
module cab_blend (
	input  cab_pkg::cab_in_t  pix,
	input  cab_pkg::cab_pos_t pos,
	input  cab_pkg::cab_cfg_t cfg,
	output cab_pkg::cab_out_t res
);

	localparam int POS_W = cab_pkg::POS_W;

	logic [7:0]  alpha;
	logic [7:0]  inv_alpha;
	logic [7:0]  s_ch [3];
	logic [7:0]  d_ch [3];
	logic [16:0] mix  [3];
	logic [16:0] qsum [3];
	logic [7:0]  q_ch [3];
	logic        in_frame;
	logic signed [POS_W-1:0] fw_ext;
	logic signed [POS_W-1:0] fh_ext;

	assign alpha     = pix.source_pixel[31:24];
	assign inv_alpha = 8'hFF - alpha;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			s_ch[c] = pix.source_pixel[8*c +: 8];
			d_ch[c] = pix.dest_pixel[8*c +: 8];
			mix[c]  = 17'(d_ch[c] * inv_alpha) + 17'(s_ch[c] * alpha);
			// exact t/255 for t < 65535
			qsum[c] = mix[c] + 17'(1) + 17'(mix[c] >> 8);
			q_ch[c] = qsum[c][15:8];
		end
	end

	assign fw_ext = $signed(POS_W'(cfg.frame_width));
	assign fh_ext = $signed(POS_W'(cfg.frame_height));
	assign in_frame = !pos.x[POS_W-1] && !pos.y[POS_W-1] &&
		(pos.x < fw_ext) && (pos.y < fh_ext);

	always_comb begin
		res.last = pos.last;
		if (in_frame) begin
			res.write_enable  = 1'b1;
			res.dest_x        = pos.x[cab_pkg::COORD_W-1:0];
			res.dest_y        = pos.y[cab_pkg::COORD_W-1:0];
			res.blended_pixel = {q_ch[2], q_ch[1], q_ch[0]};
		end else begin
			res.write_enable  = 1'b0;
			res.dest_x        = '0;
			res.dest_y        = '0;
			res.blended_pixel = '0;
		end
	end

endmodule

>>> src/clipped_alpha_blit.sv
// ----------------------------------------------------------------------------
// clipped_alpha_blit
// Blends a bitmap centered on a point onto a frame, one pixel per item,
// clipping pixels that fall outside the frame.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes through the input reg and then the result
//   reg before its result can be taken.
// Throughput: 1 item per cycle while the sink does not stall; a new item is also
//   taken while a finished result waits at the output, if stage 1 is empty.
// Reset: arst_n clears counters, pipeline valids and sets registers to
//   center 0,0 and all sizes 1. Config port is always ready.
// ----------------------------------------------------------------------------
module clipped_alpha_blit #(
	parameter int MAX_DIM = cab_pkg::MAX_DIM_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// input item channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  cab_pkg::cab_in_t          in_data,
	// result item channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output cab_pkg::cab_out_t         out_data,
	// register write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [cab_pkg::IDX_W-1:0] cfg_index,
	input  logic [cab_pkg::CFG_W-1:0] cfg_data
);

	cab_pkg::cab_cfg_t cfg;
	cab_pkg::cab_pos_t pos;
	cab_pkg::cab_out_t res;

	// Stage 1: captured pixels and frame position
	logic              s1_valid_s1;
	cab_pkg::cab_in_t  pix_s1;
	cab_pkg::cab_pos_t pos_s1;

	// Stage 2: result register
	logic              out_valid_q;
	cab_pkg::cab_out_t out_q;

	logic out_adv;
	logic s1_adv;
	logic accept;

	// The user must let writes land only while idle; the block does not enforce this and gives no back-pressure.
	assign cfg_ready = 1'b1;

	cab_cfg_regs #(
		.MAX_DIM (MAX_DIM)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Counters step once per accepted item; position uses the pre-step count.
	cab_addr_gen #(
		.MAX_DIM (MAX_DIM)
	) u_addr (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.cfg     (cfg),
		.pos     (pos)
	);

	// Handshake: output register frees when empty or taken; stage 1 frees
	// when empty or when it can move into the output register.
	assign out_adv  = !out_valid_q || !out_stall;
	assign s1_adv   = !s1_valid_s1 || out_adv;
	assign in_stall = !s1_adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			s1_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= in_data;
			pos_s1 <= pos;
		end
	end

	// Clip test and blend between stage 1 and the result register
	cab_blend u_blend (
		.pix (pix_s1),
		.pos (pos_s1),
		.cfg (cfg),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && s1_valid_s1) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	// Clipped results carry zero position and color
	a_clip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.write_enable |->
			out_q.dest_x == '0 && out_q.dest_y == '0 && out_q.blended_pixel == '0)
		else $error("clipped result with nonzero payload");

	// A write always lands inside the frame
	a_write_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.write_enable |->
			cab_pkg::SIZE_W'(out_q.dest_x) < cfg.frame_width &&
			cab_pkg::SIZE_W'(out_q.dest_y) < cfg.frame_height)
		else $error("write outside frame");

	// Input is held off only when both stages are full and the sink stalls
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_s1 && out_valid_q && out_stall)
		else $error("input stalled with room in pipeline");
`endif

endmodule
